FILE: sv/vfd_pkg.sv
// ----------------------------------------------------------------------------
// vfd_pkg
// Types and constants shared by the vision frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vfd_pkg;

  // item operations
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_RESYNC = 1'b1;

  // framing bytes
  localparam logic [7:0] HDR_BYTE   = 8'hA3;
  localparam logic [7:0] TYPE_ANGLE = 8'hB3;
  localparam logic [7:0] TYPE_DIR   = 8'hB4;
  localparam logic [7:0] END_BYTE   = 8'hFF;

  // frame lengths (including header, type and end) needed for a good frame
  localparam int unsigned MIN_ANGLE_LEN = 5;
  localparam int unsigned MIN_POS_LEN   = 7;
  localparam int unsigned MIN_DIR_LEN   = 4;

  // first payload position and number of payload bytes kept for decode
  localparam int unsigned PAY_FIRST = 2;
  localparam int unsigned PAY_KEEP  = 4;

  typedef enum logic [1:0] {
    PH_WAIT_HDR  = 2'd0,
    PH_WAIT_TYPE = 2'd1,
    PH_COLLECT   = 2'd2
  } phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } vfd_in_t;

  typedef struct packed {
    logic signed [15:0] angle_hundredths;
    logic signed [15:0] position_x_hundredths;
    logic [7:0]         direction_code;
    logic               angle_new;
    logic               position_new;
    logic               direction_new;
    logic               frame_ok;
    logic               frame_error;
    logic [31:0]        bytes_seen;
    logic [31:0]        frames_good;
    logic [31:0]        frames_bad;
  } vfd_out_t;

endpackage

`default_nettype wire

FILE: sv/vfd_core.sv
// ----------------------------------------------------------------------------
// vfd_core
// Frame parser state, payload capture, decode and running counters. Computes
// the result for the item at its input and commits state when stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_core #(
  parameter int unsigned MAX_FRAME_BYTES = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire vfd_pkg::vfd_in_t item_i,
  output vfd_pkg::vfd_out_t     result_o
);

  localparam int unsigned IdxW = $clog2(MAX_FRAME_BYTES + 1);

  vfd_pkg::phase_e    phase_q, phase_d;
  logic               is_dir_q, is_dir_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    idx_inc;
  logic signed [15:0] angle_q, angle_d;
  logic signed [15:0] pos_q, pos_d;
  logic [7:0]         dir_q, dir_d;
  logic [31:0]        bytes_q, bytes_d;
  logic [31:0]        good_q, good_d;
  logic [31:0]        bad_q, bad_d;
  logic [7:0]         pay_q [vfd_pkg::PAY_KEEP];
  logic               pay_we;
  logic               f_angle, f_pos, f_dir, f_ok, f_err;
  logic [1:0]         bad_inc;
  logic [7:0]         b;

  assign b       = item_i.rx_byte;
  assign idx_inc = idx_q + IdxW'(1);

  // next state, decode and flags
  always_comb begin
    phase_d = phase_q;
    is_dir_d = is_dir_q;
    idx_d = idx_q;
    angle_d = angle_q;
    pos_d = pos_q;
    dir_d = dir_q;
    bytes_d = bytes_q;
    pay_we = 1'b0;
    f_angle = 1'b0;
    f_pos = 1'b0;
    f_dir = 1'b0;
    f_ok = 1'b0;
    f_err = 1'b0;
    bad_inc = 2'd0;
    if (item_i.op == vfd_pkg::OP_RESYNC) begin
      phase_d = vfd_pkg::PH_WAIT_HDR;
      idx_d = '0;
    end else begin
      bytes_d = bytes_q + 32'd1;
      case (phase_q)
        vfd_pkg::PH_WAIT_TYPE: begin
          if (b == vfd_pkg::TYPE_ANGLE || b == vfd_pkg::TYPE_DIR) begin
            is_dir_d = (b == vfd_pkg::TYPE_DIR);
            idx_d = idx_inc;
            phase_d = vfd_pkg::PH_COLLECT;
          end else if (b == vfd_pkg::HDR_BYTE) begin
            // repeated header restarts the frame
            idx_d = IdxW'(1);
          end else begin
            phase_d = vfd_pkg::PH_WAIT_HDR;
            f_err = 1'b1;
            bad_inc = 2'd1;
          end
        end
        vfd_pkg::PH_COLLECT: begin
          idx_d = idx_inc;
          pay_we = 1'b1;
          if (b == vfd_pkg::END_BYTE) begin
            if (!is_dir_q && idx_inc >= IdxW'(vfd_pkg::MIN_ANGLE_LEN)) begin
              angle_d = {pay_q[0], pay_q[1]};
              f_angle = 1'b1;
              if (idx_inc >= IdxW'(vfd_pkg::MIN_POS_LEN)) begin
                pos_d = {pay_q[2], pay_q[3]};
                f_pos = 1'b1;
              end
              f_ok = 1'b1;
            end else if (is_dir_q && idx_inc >= IdxW'(vfd_pkg::MIN_DIR_LEN)) begin
              dir_d = pay_q[0];
              f_dir = 1'b1;
              f_ok = 1'b1;
            end else begin
              f_err = 1'b1;
              bad_inc = 2'd1;
            end
            phase_d = vfd_pkg::PH_WAIT_HDR;
          end
          // overflow counts on top of any end-of-frame outcome
          if (idx_inc >= IdxW'(MAX_FRAME_BYTES)) begin
            phase_d = vfd_pkg::PH_WAIT_HDR;
            f_err = 1'b1;
            bad_inc = bad_inc + 2'd1;
          end
        end
        default: begin
          if (b == vfd_pkg::HDR_BYTE) begin
            idx_d = IdxW'(1);
            phase_d = vfd_pkg::PH_WAIT_TYPE;
          end else begin
            phase_d = vfd_pkg::PH_WAIT_HDR;
          end
        end
      endcase
    end
    good_d = good_q + {31'd0, f_ok};
    bad_d  = bad_q + {30'd0, bad_inc};
  end

  // result for the current item
  always_comb begin
    result_o.angle_hundredths      = angle_d;
    result_o.position_x_hundredths = pos_d;
    result_o.direction_code        = dir_d;
    result_o.angle_new             = f_angle;
    result_o.position_new          = f_pos;
    result_o.direction_new         = f_dir;
    result_o.frame_ok              = f_ok;
    result_o.frame_error           = f_err;
    result_o.bytes_seen            = bytes_d;
    result_o.frames_good           = good_d;
    result_o.frames_bad            = bad_d;
  end

  // parser state and latest values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= vfd_pkg::PH_WAIT_HDR;
      is_dir_q <= 1'b0;
      idx_q    <= '0;
      angle_q  <= '0;
      pos_q    <= '0;
      dir_q    <= '0;
      bytes_q  <= '0;
      good_q   <= '0;
      bad_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      is_dir_q <= is_dir_d;
      idx_q    <= idx_d;
      angle_q  <= angle_d;
      pos_q    <= pos_d;
      dir_q    <= dir_d;
      bytes_q  <= bytes_d;
      good_q   <= good_d;
      bad_q    <= bad_d;
    end
  end

  // capture of the payload bytes used by decode
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < vfd_pkg::PAY_KEEP; k++) begin
      if (step_i && pay_we && idx_q == IdxW'(vfd_pkg::PAY_FIRST + k)) begin
        pay_q[k] <= b;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/vision_frame_deframer.sv
// ----------------------------------------------------------------------------
// vision_frame_deframer
// Byte stream deframer for angle, position and direction frames, with
// running byte, good frame and bad frame counters.
//
//   channel   signals                               payload
//   input     in_valid_i, in_ready_o, in_data_i     vfd_in_t  (op, rx_byte)
//   output    out_valid_o, out_ready_i, out_data_o  vfd_out_t (one per item)
//
// One item per cycle while the result side does not stall; an item passes
// the input register, the parser logic and then the result register.
// Each item yields exactly one result.
// Reset clears the parser to waiting for a header and zeroes all counters
// and latest values.
// A stalled result register holds the input register; the input register
// still takes a new item in the cycle its item moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module vision_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire vfd_pkg::vfd_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output vfd_pkg::vfd_out_t      out_data_o
);

  logic              in_valid_q;
  vfd_pkg::vfd_in_t  in_q;
  logic              out_valid_q;
  vfd_pkg::vfd_out_t out_q;
  vfd_pkg::vfd_out_t result;
  logic              advance;

  // item moves from input register to result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  vfd_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_q),
    .result_o(result)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sim/vfd_frame_checker.sv
// ----------------------------------------------------------------------------
// vfd_frame_checker
// Watches both channels of the vision frame deframer, runs its own deframer
// on every accepted input item and compares each result item, field by
// field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire vfd_pkg::vfd_in_t  in_data_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire vfd_pkg::vfd_out_t out_data_i,
  output int                     mismatches_o,
  output int                     reports_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state of the predictor
  vfd_pkg::phase_e    parse_phase;
  logic               frame_dir;
  logic [7:0]         frame_buf [16];
  logic [7:0]         frame_len;
  logic signed [15:0] last_angle;
  logic signed [15:0] last_pos;
  logic [7:0]         last_dir;
  logic [31:0]        byte_cnt;
  logic [31:0]        good_cnt;
  logic [31:0]        bad_cnt;

  vfd_pkg::vfd_out_t predicted_reports [$];
  int                mismatch_cnt;
  int                results_seen;

  // append one byte to the frame being collected
  function automatic void store_byte(input logic [7:0] b);
    frame_buf[frame_len[3:0]] = b;
    frame_len = frame_len + 8'd1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
      end
    end
  endfunction

  // advance the deframer by one item and build the report it yields
  task automatic deframe_step(input vfd_pkg::vfd_in_t item, output vfd_pkg::vfd_out_t res);
    logic [7:0] b;
    b   = item.rx_byte;
    res = '0;
    if (item.op == vfd_pkg::OP_RESYNC) begin
      // drop any partial frame, nothing counted
      parse_phase = vfd_pkg::PH_WAIT_HDR;
      frame_len   = '0;
    end else begin
      byte_cnt++;
      case (parse_phase)
        vfd_pkg::PH_WAIT_TYPE: begin
          if (b == vfd_pkg::TYPE_ANGLE || b == vfd_pkg::TYPE_DIR) begin
            frame_dir = (b == vfd_pkg::TYPE_DIR);
            store_byte(b);
            parse_phase = vfd_pkg::PH_COLLECT;
          end else if (b == vfd_pkg::HDR_BYTE) begin
            // repeated header restarts the frame
            frame_len = '0;
            store_byte(b);
          end else begin
            parse_phase = vfd_pkg::PH_WAIT_HDR;
            bad_cnt++;
            res.frame_error = 1'b1;
          end
        end
        vfd_pkg::PH_COLLECT: begin
          store_byte(b);
          if (b == vfd_pkg::END_BYTE) begin
            if (!frame_dir && frame_len >= vfd_pkg::MIN_ANGLE_LEN) begin
              last_angle    = {frame_buf[vfd_pkg::PAY_FIRST],
                               frame_buf[vfd_pkg::PAY_FIRST + 1]};
              res.angle_new = 1'b1;
              if (frame_len >= vfd_pkg::MIN_POS_LEN) begin
                last_pos         = {frame_buf[vfd_pkg::PAY_FIRST + 2],
                                    frame_buf[vfd_pkg::PAY_FIRST + 3]};
                res.position_new = 1'b1;
              end
              good_cnt++;
              res.frame_ok = 1'b1;
            end else if (frame_dir && frame_len >= vfd_pkg::MIN_DIR_LEN) begin
              last_dir          = frame_buf[vfd_pkg::PAY_FIRST];
              res.direction_new = 1'b1;
              good_cnt++;
              res.frame_ok = 1'b1;
            end else begin
              bad_cnt++;
              res.frame_error = 1'b1;
            end
            parse_phase = vfd_pkg::PH_WAIT_HDR;
          end
          // overflow counts even when this byte closed a good frame
          if (frame_len >= MAX_FRAME_BYTES) begin
            parse_phase = vfd_pkg::PH_WAIT_HDR;
            bad_cnt++;
            res.frame_error = 1'b1;
          end
        end
        default: begin
          if (b == vfd_pkg::HDR_BYTE) begin
            frame_len = '0;
            store_byte(b);
            parse_phase = vfd_pkg::PH_WAIT_TYPE;
          end else begin
            parse_phase = vfd_pkg::PH_WAIT_HDR;
          end
        end
      endcase
    end
    res.angle_hundredths      = last_angle;
    res.position_x_hundredths = last_pos;
    res.direction_code        = last_dir;
    res.bytes_seen            = byte_cnt;
    res.frames_good           = good_cnt;
    res.frames_bad            = bad_cnt;
  endtask

  // compare results first, then predict for the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    vfd_pkg::vfd_out_t want;
    if (!rst_ni) begin
      parse_phase = vfd_pkg::PH_WAIT_HDR;
      frame_dir   = 1'b0;
      frame_len   = '0;
      last_angle  = '0;
      last_pos    = '0;
      last_dir    = '0;
      byte_cnt    = '0;
      good_cnt    = '0;
      bad_cnt     = '0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      predicted_reports.delete();
      mismatch_cnt = 0;
      results_seen = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_reports.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("result %0d arrived with nothing predicted: %h", results_seen,
                     out_data_i);
          end
        end else begin
          want = predicted_reports.pop_front();
          check_field("angle_hundredths", want.angle_hundredths,
                      out_data_i.angle_hundredths);
          check_field("position_x_hundredths", want.position_x_hundredths,
                      out_data_i.position_x_hundredths);
          check_field("direction_code", want.direction_code, out_data_i.direction_code);
          check_field("angle_new", want.angle_new, out_data_i.angle_new);
          check_field("position_new", want.position_new, out_data_i.position_new);
          check_field("direction_new", want.direction_new, out_data_i.direction_new);
          check_field("frame_ok", want.frame_ok, out_data_i.frame_ok);
          check_field("frame_error", want.frame_error, out_data_i.frame_error);
          check_field("bytes_seen", want.bytes_seen, out_data_i.bytes_seen);
          check_field("frames_good", want.frames_good, out_data_i.frames_good);
          check_field("frames_bad", want.frames_bad, out_data_i.frames_bad);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        deframe_step(in_data_i, want);
        predicted_reports.push_back(want);
      end
    end
    mismatches_o  <= mismatch_cnt;
    reports_due_o <= int'(predicted_reports.size());
  end

endmodule

`default_nettype wire

FILE: sim/vision_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// vision_frame_deframer_tb
// Drives directed and random byte streams into the deframer, with random
// idle bursts on both channels, a long result stall and drain pauses, and
// reports the verdict from the checker's mismatch and pending report counts.
// ----------------------------------------------------------------------------
`default_nettype none

module vision_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_BYTES_MAX = 8;
  localparam int          ITEM_TARGET     = 1150;
  localparam int          CALM_TAIL       = 150;
  localparam int          LONG_HOLD       = 48;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          WATCHDOG_LIMIT  = 1000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  vfd_pkg::vfd_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  vfd_pkg::vfd_out_t out_data;

  int mismatches;
  int reports_due;
  int quiet_cycles;
  int items_driven;
  bit bursts_on;
  bit hold_request;

  // opening frames: angle minimum without position, header restart with a
  // direction frame, bad type, short direction frame, good frame with
  // position that also overflows
  logic [7:0] opening_bytes [23] = '{
    8'hA3, 8'hB3, 8'h80, 8'h00, 8'hFF,
    8'hA3, 8'hA3, 8'hB4, 8'h7F, 8'hFF,
    8'hA3, 8'h55,
    8'hA3, 8'hB4, 8'hFF,
    8'hA3, 8'hB3, 8'h7F, 8'hFE, 8'h00, 8'h01, 8'h02, 8'hFF
  };

  vision_frame_deframer #(
    .MAX_FRAME_BYTES(FRAME_BYTES_MAX)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  vfd_frame_checker #(
    .MAX_FRAME_BYTES(FRAME_BYTES_MAX)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .reports_due_o(reports_due)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, with an optional idle burst before it
  task automatic send_item(input vfd_pkg::vfd_in_t item);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    vfd_pkg::vfd_in_t item;
    item.op      = vfd_pkg::OP_BYTE;
    item.rx_byte = b;
    send_item(item);
    items_driven++;
  endtask

  task automatic send_resync(input logic [7:0] b);
    vfd_pkg::vfd_in_t item;
    item.op      = vfd_pkg::OP_RESYNC;
    item.rx_byte = b;
    send_item(item);
    items_driven++;
  endtask

  // header, sometimes a repeated header, type, random payload, optional end
  task automatic send_frame(input logic [7:0] kind, input int pay_len, input bit closed);
    logic [7:0] b;
    send_byte(vfd_pkg::HDR_BYTE);
    if ($urandom_range(0, 9) == 0) send_byte(vfd_pkg::HDR_BYTE);
    send_byte(kind);
    repeat (pay_len) begin
      case ($urandom_range(0, 23))
        0:       b = 8'h00;
        1:       b = 8'h7F;
        2:       b = 8'h80;
        3:       b = vfd_pkg::END_BYTE;
        4:       b = vfd_pkg::HDR_BYTE;
        default: b = 8'($urandom_range(0, 254));
      endcase
      send_byte(b);
    end
    if (closed) send_byte(vfd_pkg::END_BYTE);
  endtask

  // result side: random stall bursts and one long hold on request
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                sel;
    int                pauses_done;
    bit                hold_done;
    logic [7:0]        kind;
    logic [7:0]        b;
    vfd_pkg::vfd_in_t  noise;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    bursts_on    = 1'b1;
    hold_request = 1'b0;
    items_driven = 0;
    pauses_done  = 0;
    hold_done    = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    send_resync(8'hFF);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    send_byte(vfd_pkg::HDR_BYTE);
    send_byte(vfd_pkg::TYPE_DIR);
    send_byte(8'h42);
    send_resync(8'h00);

    // random frames, mostly well formed
    while (items_driven < ITEM_TARGET) begin
      if (!hold_done && items_driven >= 350) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (pauses_done < 2 && items_driven >= 600 + 300 * pauses_done) begin
        in_valid <= 1'b0;
        wait (reports_due == 0);
        @(negedge clk);
        pauses_done++;
      end
      if (items_driven >= ITEM_TARGET - CALM_TAIL) bursts_on = 1'b0;
      sel  = $urandom_range(0, 99);
      kind = $urandom_range(0, 1) ? vfd_pkg::TYPE_DIR : vfd_pkg::TYPE_ANGLE;
      if (sel < 60) begin
        send_frame(kind,
                   (kind == vfd_pkg::TYPE_DIR) ? $urandom_range(0, 4) : $urandom_range(0, 5),
                   1'b1);
      end else if (sel < 70) begin
        // no end byte: runs into the length limit
        send_frame(kind, $urandom_range(6, 8), 1'b0);
      end else if (sel < 80) begin
        send_frame(kind, $urandom_range(0, 4), 1'b0);
        if ($urandom_range(0, 1)) send_resync(8'($urandom_range(0, 255)));
      end else if (sel < 88) begin
        send_byte(vfd_pkg::HDR_BYTE);
        do b = 8'($urandom_range(0, 255));
        while (b == vfd_pkg::HDR_BYTE || b == vfd_pkg::TYPE_ANGLE || b == vfd_pkg::TYPE_DIR);
        send_byte(b);
      end else if (sel < 93) begin
        send_resync(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          noise.op      = 1'($urandom_range(0, 1));
          noise.rx_byte = 8'($urandom_range(0, 255));
          send_item(noise);
          items_driven++;
        end
      end
    end

    // drain and verdict
    in_valid <= 1'b0;
    wait (reports_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && reports_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
